[design/sha_pkg.sv]
// Package for the SHA-1/SHA-0 hash engine: payload structs, constants and round functions.
// Used by every module of the engine; depends on nothing.
package sha_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;
  } out_item_t;

  // One word for the compression back end, with block markers.
  typedef struct packed {
    logic [31:0] word;
    logic        block_end;
    logic        msg_end;
  } blk_word_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } core_state_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_PAD,
    FS_LEN_HI,
    FS_LEN_LO
  } front_state_t;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] k;
    if (t < 7'd20) k = 32'h5a827999;
    else if (t < 7'd40) k = 32'h6ed9eba1;
    else if (t < 7'd60) k = 32'h8f1bbcdc;
    else k = 32'hca62c1d6;
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (t < 7'd20) f = (b & c) | (~b & d);
    else if (t >= 7'd40 && t < 7'd60) f = (b & c) | (b & d) | (c & d);
    else f = b ^ c ^ d;
    return f;
  endfunction

endpackage

[design/sha_front.sv]
// Front end of the SHA engine: takes message words, pads the last one and appends the length.
// Depends on sha_pkg.
module sha_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sha_pkg::in_item_t    in_item,
  output logic                 q_push,
  input  logic                 q_full,
  output sha_pkg::blk_word_t   q_word
);

  sha_pkg::front_state_t state_r, state_nxt;
  logic [3:0]  fill_r, fill_nxt;
  logic [63:0] len_r, len_nxt;
  logic        pend_r, pend_nxt;
  logic [2:0]  cnt;
  logic [31:0] mask, padw;

  always_comb begin
    cnt = (in_item.byte_count > 3'd4) ? 3'd4 : in_item.byte_count;
    unique case (cnt)
      3'd0: begin mask = 32'h0;        padw = 32'h80000000; end
      3'd1: begin mask = 32'hff000000; padw = 32'h00800000; end
      3'd2: begin mask = 32'hffff0000; padw = 32'h00008000; end
      3'd3: begin mask = 32'hffffff00; padw = 32'h00000080; end
      default: begin mask = 32'hffffffff; padw = 32'h0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha_pkg::FS_IDLE;
      fill_r  <= '0;
      len_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      len_r   <= len_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    len_nxt   = len_r;
    pend_nxt  = pend_r;
    q_push    = 1'b0;
    q_word    = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      sha_pkg::FS_IDLE: begin
        in_ready = !q_full;
        if (in_valid && !q_full) begin
          q_push = 1'b1;
          fill_nxt = fill_r + 4'd1;
          if (!in_item.last_word) begin
            q_word.word = in_item.data_word;
            len_nxt = len_r + 64'd32;
          end else begin
            q_word.word = (in_item.data_word & mask) | padw;
            len_nxt = len_r + {58'd0, cnt, 3'd0};
            if (cnt == 3'd4) begin
              state_nxt = sha_pkg::FS_PAD;
              pend_nxt = 1'b1;
            end else if (fill_r == 4'd13) state_nxt = sha_pkg::FS_LEN_HI;
            else state_nxt = sha_pkg::FS_PAD;
          end
          q_word.block_end = (fill_r == 4'd15);
        end
      end
      sha_pkg::FS_PAD: begin
        // After a full last word the first pad word carries the 0x80 marker byte.
        if (!q_full) begin
          q_push = 1'b1;
          q_word.word = pend_r ? 32'h80000000 : 32'h0;
          q_word.block_end = (fill_r == 4'd15);
          fill_nxt = fill_r + 4'd1;
          pend_nxt = 1'b0;
          if (fill_r == 4'd13) state_nxt = sha_pkg::FS_LEN_HI;
        end
      end
      sha_pkg::FS_LEN_HI: begin
        if (!q_full) begin
          q_push = 1'b1;
          q_word.word = len_r[63:32];
          fill_nxt = fill_r + 4'd1;
          state_nxt = sha_pkg::FS_LEN_LO;
        end
      end
      default: begin
        if (!q_full) begin
          q_push = 1'b1;
          q_word.word = len_r[31:0];
          q_word.block_end = 1'b1;
          q_word.msg_end = 1'b1;
          fill_nxt = '0;
          len_nxt = '0;
          state_nxt = sha_pkg::FS_IDLE;
        end
      end
    endcase
  end

endmodule

[design/sha_queue.sv]
// Short queue between the SHA front end and the compression core.
// Depends on sha_pkg.
module sha_queue #(
  parameter int unsigned Depth = sha_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  sha_pkg::blk_word_t wdata,
  input  logic               pop,
  output logic               empty,
  output sha_pkg::blk_word_t rdata
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  sha_pkg::blk_word_t mem_r [Depth];
  logic [Aw-1:0] wp_r, rp_r;
  logic [Aw:0]   cnt_r;

  assign full  = (cnt_r == (Aw+1)'(Depth));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= (wp_r == Aw'(Depth - 1)) ? '0 : wp_r + 1'b1;
      if (pop && !empty) rp_r <= (rp_r == Aw'(Depth - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + {{Aw{1'b0}}, push && !full} - {{Aw{1'b0}}, pop && !empty};
    end
  end

endmodule

[design/sha_core.sv]
// Compression core of the SHA engine: 16-word window schedule, one round per cycle.
// Depends on sha_pkg.
module sha_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                hash_mode,
  input  logic                q_empty,
  output logic                q_pop,
  input  sha_pkg::blk_word_t  q_word,
  output logic                out_valid,
  input  logic                out_ready,
  output sha_pkg::out_item_t  out_item
);

  sha_pkg::core_state_t state_r, state_nxt;
  logic [31:0] w_r [16];
  logic [31:0] h_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [6:0]  t_r;
  logic [3:0]  ld_r;
  logic        msg_end_r;
  logic [2:0]  idx_r;
  logic [31:0] x, wn, tmp;

  always_comb begin
    x = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    wn = hash_mode ? {x[30:0], x[31]} : x;
    tmp = {a_r[26:0], a_r[31:27]} + sha_pkg::round_f(t_r, b_r, c_r, d_r) + e_r +
          sha_pkg::round_k(t_r) + w_r[0];
  end

  assign q_pop     = (state_r == sha_pkg::ST_LOAD) && !q_empty;
  assign out_valid = (state_r == sha_pkg::ST_EMIT);
  assign out_item.digest_word = h_r[idx_r];
  assign out_item.word_index  = idx_r;
  assign out_item.digest_last = (idx_r == 3'd4);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sha_pkg::ST_LOAD:  if (!q_empty && q_word.block_end) state_nxt = sha_pkg::ST_ROUND;
      sha_pkg::ST_ROUND: if (t_r == 7'd79) state_nxt = sha_pkg::ST_ADD;
      sha_pkg::ST_ADD:   state_nxt = msg_end_r ? sha_pkg::ST_EMIT : sha_pkg::ST_LOAD;
      default:           if (out_ready && idx_r == 3'd4) state_nxt = sha_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha_pkg::ST_LOAD;
      t_r <= '0;
      ld_r <= '0;
      idx_r <= '0;
      msg_end_r <= 1'b0;
      for (int i = 0; i < 5; i++) h_r[i] <= sha_pkg::H_INIT[i];
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        sha_pkg::ST_LOAD: begin
          if (!q_empty) begin
            w_r[ld_r] <= q_word.word;
            ld_r <= ld_r + 4'd1;
            msg_end_r <= q_word.msg_end;
            if (q_word.block_end) begin
              t_r <= '0;
              a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
            end
          end
        end
        sha_pkg::ST_ROUND: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= wn;
          e_r <= d_r; d_r <= c_r; c_r <= {b_r[1:0], b_r[31:2]}; b_r <= a_r; a_r <= tmp;
          t_r <= t_r + 7'd1;
        end
        sha_pkg::ST_ADD: begin
          h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r; h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r; h_r[4] <= h_r[4] + e_r;
          ld_r <= '0;
          idx_r <= '0;
        end
        default: begin
          if (out_ready) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd4) begin
              idx_r <= '0;
              for (int i = 0; i < 5; i++) h_r[i] <= sha_pkg::H_INIT[i];
            end
          end
        end
      endcase
    end
  end

endmodule

[design/sha0_sha1_hash_engine.sv]
// SHA-1/SHA-0 hash engine top level: front end, word queue and compression core.
// Depends on sha_pkg, sha_front, sha_queue and sha_core.
// A block is loaded as 16 queue words, then takes 80 rounds and one add step; the single
// round unit of the core sets the throughput, and the core takes no words while it works.
// Digest words follow the last block's add step, one per cycle while out_pop is high.
// Synchronous active-low reset restores the initial chaining values and SHA-1 mode.
module sha0_sha1_hash_engine #(
  parameter int unsigned QueueDepth = sha_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  sha_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output sha_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

  logic mode_r;
  logic q_push, q_full, q_pop, q_empty, in_ready, out_valid;
  sha_pkg::blk_word_t q_wword, q_rword;

  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= 1'b1;
    else if (cfg_we) mode_r <= cfg_wdata;
  end

  assign in_full   = !in_ready;
  assign out_empty = !out_valid;

  sha_front u_front (
    .clk, .rst_n, .in_valid(in_push), .in_ready, .in_item,
    .q_push, .q_full, .q_word(q_wword)
  );

  sha_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst_n, .push(q_push), .full(q_full), .wdata(q_wword),
    .pop(q_pop), .empty(q_empty), .rdata(q_rword)
  );

  sha_core u_core (
    .clk, .rst_n, .hash_mode(mode_r), .q_empty, .q_pop, .q_word(q_rword),
    .out_valid, .out_ready(out_pop), .out_item
  );

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_item.word_index <= 3'd4) else $error("digest index out of range");
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_item.digest_last == (out_item.word_index == 3'd4)))
    else $error("digest_last mismatch");

endmodule

[sim/sha_digest_checker.sv]
// Checker for the SHA-1/SHA-0 hash engine: watches the item, result and register ports.
// It predicts each digest from its own copy of the hash state and compares it word by word.
// Depends on sha_pkg for the payload structs.
module sha_digest_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  sha_pkg::in_item_t  in_item,
  input  logic               out_empty,
  input  logic               out_pop,
  input  sha_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  output int                 fail_count,
  output int                 pending,
  output int                 digests_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0]        chain [5];
  logic [31:0]        blk_words [16];
  int unsigned        blk_fill;
  logic [63:0]        msg_bits;
  logic               sha1_sel;
  sha_pkg::out_item_t digest_q [$];

  task automatic restart_message();
    for (int i = 0; i < 5; i++) chain[i] = sha_pkg::H_INIT[i];
    blk_fill = 0;
    msg_bits = '0;
  endtask

  task automatic compress_block();
    logic [31:0] sched [80];
    logic [31:0] a, b, c, d, e, f, k, x, tmp;
    for (int t = 0; t < 16; t++) sched[t] = blk_words[t];
    for (int t = 16; t < 80; t++) begin
      x = sched[t-3] ^ sched[t-8] ^ sched[t-14] ^ sched[t-16];
      sched[t] = sha1_sel ? {x[30:0], x[31]} : x;
    end
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5a827999;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ed9eba1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8f1bbcdc;
      end else begin
        f = b ^ c ^ d;
        k = 32'hca62c1d6;
      end
      tmp = {a[26:0], a[31:27]} + f + e + k + sched[t];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = tmp;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endtask

  task automatic absorb_word(input logic [31:0] w);
    blk_words[blk_fill] = w;
    blk_fill++;
    if (blk_fill == 16) begin
      compress_block();
      blk_fill = 0;
    end
  endtask

  task automatic take_item(input sha_pkg::in_item_t it);
    int unsigned        cnt;
    logic [31:0]        mask;
    sha_pkg::out_item_t res;
    if (!it.last_word) begin
      absorb_word(it.data_word);
      msg_bits += 64'd32;
      return;
    end
    cnt = (it.byte_count > 3'd4) ? 4 : it.byte_count;
    msg_bits += 64'(cnt * 8);
    if (cnt == 4) begin
      absorb_word(it.data_word);
      absorb_word(32'h80000000);
    end else begin
      mask = (cnt == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * cnt));
      absorb_word((it.data_word & mask) | (32'h80 << (24 - 8 * cnt)));
    end
    while (blk_fill != 14) absorb_word(32'h0);
    absorb_word(msg_bits[63:32]);
    absorb_word(msg_bits[31:0]);
    for (int i = 0; i < 5; i++) begin
      res.digest_word = chain[i];
      res.word_index  = 3'(i);
      res.digest_last = (i == 4);
      digest_q.push_back(res);
    end
    restart_message();
  endtask

  always @(posedge clk) begin
    sha_pkg::out_item_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      restart_message();
      sha1_sel = 1'b1;
      digest_q.delete();
    end else begin
      if (cfg_we) sha1_sel = cfg_wdata;
      if (in_push && !in_full) take_item(in_item);
      if (out_pop && !out_empty) begin
        digests_seen <= digests_seen + 1;
        if (digest_q.size() == 0) begin
          $error("unexpected result item: digest_word %h word_index %0d",
                 out_item.digest_word, out_item.word_index);
          errs++;
        end else begin
          want = digest_q.pop_front();
          if (out_item.digest_word !== want.digest_word) begin
            $error("digest_word: expected %h actual %h", want.digest_word, out_item.digest_word);
            errs++;
          end
          if (out_item.word_index !== want.word_index) begin
            $error("word_index: expected %0d actual %0d", want.word_index, out_item.word_index);
            errs++;
          end
          if (out_item.digest_last !== want.digest_last) begin
            $error("digest_last: expected %0d actual %0d", want.digest_last,
                   out_item.digest_last);
            errs++;
          end
        end
      end
    end
    fail_count <= fail_count + errs;
    pending <= digest_q.size();
  end

endmodule

[sim/sha0_sha1_hash_engine_tb.sv]
// Testbench top for the SHA-1/SHA-0 hash engine: clock, reset, message stimulus and verdict.
// Depends on sha_pkg, the engine RTL and sha_digest_checker.
module sha0_sha1_hash_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  sha_pkg::in_item_t  in_item = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  sha_pkg::out_item_t out_item;
  logic               cfg_we = 1'b0;
  logic               cfg_wdata = 1'b0;
  int                 fail_count, pending, digests_seen;
  int                 items_sent = 0;
  int                 messages_sent = 0;
  bit                 hold_req = 1'b0;

  sha0_sha1_hash_engine u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  sha_digest_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending), .digests_seen(digests_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 2) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(15, 50);
    return $urandom_range(1, 3);
  endfunction

  task automatic put_item(input logic [31:0] d, input logic [2:0] c, input logic l);
    logic f;
    @(negedge clk);
    in_item = '{data_word: d, byte_count: c, last_word: l};
    in_push = 1'b1;
    forever begin
      f = in_full;
      @(posedge clk);
      if (!f) break;
      @(negedge clk);
    end
    items_sent++;
  endtask

  task automatic sender_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      in_push = 1'b0;
    end
  endtask

  task automatic send_message(input int n_words, input logic [2:0] last_cnt,
                              input bit gaps);
    for (int i = 0; i < n_words; i++) begin
      put_item($urandom, 3'($urandom), 1'b0);
      if (gaps) sender_gap(pick_gap());
    end
    put_item($urandom, last_cnt, 1'b1);
    if (gaps) sender_gap(pick_gap());
    messages_sent++;
  endtask

  task automatic drain_and_set_mode(input logic mode);
    sender_gap(1);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_wdata = mode;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Receiver: random pops with short and long gaps, plus one long hold-off on request.
  initial begin
    int gap;
    gap = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_pop = 1'b0;
        for (int n = 0; n < 400; n++) @(negedge clk);
        hold_req = 1'b0;
      end else if (gap > 0) begin
        out_pop = 1'b0;
        gap--;
      end else begin
        out_pop = 1'b1;
        gap = pick_gap();
      end
    end
  end

  initial begin
    #3_000_000;
    $display("sha0_sha1_hash_engine regression: fail");
    $finish;
  end

  initial begin
    int wait_cycles;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed messages in the reset mode, which is SHA-1.
    put_item(32'h0, 3'd0, 1'b1);
    put_item(32'hffffffff, 3'd4, 1'b1);
    put_item(32'hffffffff, 3'd1, 1'b1);
    put_item(32'hffffffff, 3'd2, 1'b1);
    put_item(32'hffffffff, 3'd3, 1'b1);
    put_item(32'h61626380, 3'd7, 1'b1);
    put_item(32'hffffffff, 3'd0, 1'b0);
    put_item(32'h0, 3'd5, 1'b1);
    messages_sent += 7;
    send_message(13, 3'd4, 1'b0);

    drain_and_set_mode(1'b0);
    put_item(32'h0, 3'd0, 1'b1);
    put_item(32'hffffffff, 3'd6, 1'b1);
    messages_sent += 2;
    send_message(14, 3'd0, 1'b0);

    // Random phases alternating between the two modes.
    for (int ph = 0; ph < 4; ph++) begin
      drain_and_set_mode(ph[0]);
      if (ph == 1) begin
        hold_req = 1'b1;
        for (int m = 0; m < 10; m++) send_message($urandom_range(0, 1), 3'($urandom), 1'b0);
      end
      while (items_sent < 60 + 60 * (ph + 1)) begin
        if ($urandom_range(0, 9) == 0)
          send_message($urandom_range(30, 66), 3'($urandom), 1'b1);
        else
          send_message($urandom_range(0, 17), 3'($urandom), 1'b1);
      end
    end

    sender_gap(1);
    while (pending != 0) @(negedge clk);
    wait_cycles = 0;
    while (wait_cycles < 30) begin
      @(negedge clk);
      wait_cycles++;
    end
    $display("Sent %0d items in %0d messages over both hash modes; %0d digest words checked.",
             items_sent, messages_sent, digests_seen);
    if (fail_count == 0) begin
      $display("sha0_sha1_hash_engine regression: pass");
    end else begin
      $display("sha0_sha1_hash_engine regression: fail");
    end
    $finish;
  end

endmodule
